/* hdl/bctd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_pkg
// Types, codes and helpers shared by the battery CAN telemetry decoder.
// ----------------------------------------------------------------------------
package bctd_pkg;

    localparam int PACK_SENSORS_DEF = 10;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  CELL_COUNT_RST = 8'd126;
    localparam logic [15:0] WDOG_TICKS_RST = 16'd10000;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_COUNT = 2'd0;
    localparam logic [1:0] CFG_WDOG_TICKS = 2'd1;

    // Frame identifiers
    localparam logic [10:0] ID_AMBIENT   = 11'h245;
    localparam logic [10:0] ID_PACK_TEMP = 11'h43c;
    localparam logic [10:0] ID_CELL_MV   = 11'h43d;
    localparam logic [10:0] ID_PACK_VOLT = 11'h444;
    localparam logic [10:0] ID_SOC       = 11'h447;
    localparam logic [10:0] ID_PID_REPLY = 11'h7ef;

    localparam logic [7:0] SUBTYPE_AMBIENT = 8'h01;
    localparam logic [7:0] FIRST_FRAME     = 8'h10;
    localparam logic [3:0] FRAME_LEN_FULL  = 4'd8;

    // Diagnostic PIDs
    localparam logic [15:0] PID_SOC         = 16'h0005;
    localparam logic [15:0] PID_VOLTAGE     = 16'h0008;
    localparam logic [15:0] PID_CURRENT     = 16'h0009;
    localparam logic [15:0] PID_CHG_POWER   = 16'h000a;
    localparam logic [15:0] PID_CHG_COUNT   = 16'h000b;
    localparam logic [15:0] PID_DIS_POWER   = 16'h000e;
    localparam logic [15:0] PID_CHG_AH      = 16'h000f;
    localparam logic [15:0] PID_DIS_AH      = 16'h0010;
    localparam logic [15:0] PID_CHG_KWH     = 16'h0011;
    localparam logic [15:0] PID_DIS_KWH     = 16'h0012;
    localparam logic [15:0] PID_CELL_MV_MIN = 16'h002b;
    localparam logic [15:0] PID_CELL_MV_MAX = 16'h002d;
    localparam logic [15:0] PID_TEMP_MIN    = 16'h002f;
    localparam logic [15:0] PID_TEMP_MAX    = 16'h0031;
    localparam logic [15:0] PID_TEMP_AVG    = 16'h0032;

    localparam logic signed [23:0] DEGC_OFFSET    = 24'sd40;
    localparam logic signed [23:0] CURRENT_OFFSET = 24'sd5000;
    localparam logic [23:0]        POWER_SCALE    = 24'd100;

    // Result kinds
    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    // Telemetry quantities
    localparam logic [4:0] Q_AMBIENT     = 5'd0;
    localparam logic [4:0] Q_PACK_VOLT   = 5'd1;
    localparam logic [4:0] Q_SOC         = 5'd2;
    localparam logic [4:0] Q_PID_SOC     = 5'd3;
    localparam logic [4:0] Q_PID_VOLT    = 5'd4;
    localparam logic [4:0] Q_PID_CURRENT = 5'd5;
    localparam logic [4:0] Q_TEMP_MIN    = 5'd6;
    localparam logic [4:0] Q_TEMP_MAX    = 5'd7;
    localparam logic [4:0] Q_TEMP_AVG    = 5'd8;
    localparam logic [4:0] Q_CELL_MIN    = 5'd9;
    localparam logic [4:0] Q_CELL_MAX    = 5'd10;
    localparam logic [4:0] Q_CELL_SPREAD = 5'd11;
    localparam logic [4:0] Q_DIS_POWER   = 5'd12;
    localparam logic [4:0] Q_CHG_POWER   = 5'd13;
    localparam logic [4:0] Q_CHG_COUNT   = 5'd14;
    localparam logic [4:0] Q_CHG_AH      = 5'd15;
    localparam logic [4:0] Q_DIS_AH      = 5'd16;
    localparam logic [4:0] Q_CHG_KWH     = 5'd17;
    localparam logic [4:0] Q_DIS_KWH     = 5'd18;
    localparam logic [4:0] Q_PACK_TEMP   = 5'd19;
    localparam logic [4:0] Q_CELL_MV     = 5'd20;

    localparam int PACK_PER_FRAME = 6;
    localparam int CELL_PER_FRAME = 3;

    typedef enum logic [1:0] {
        VMODE_SCALAR,
        VMODE_PACK,
        VMODE_CELL
    } vmode_t;

    typedef struct packed {
        logic        action;
        logic [10:0] can_id;
        logic [3:0]  frame_len;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         quantity;
        logic [7:0]         element;
        logic signed [23:0] value;
        logic               last;
    } out_t;

    // One classified item, expanded by the back end into its results
    typedef struct packed {
        logic               run_emit;
        logic               run_val;
        logic               ack;
        vmode_t             vmode;
        logic [2:0]         nval;
        logic [4:0]         q0;
        logic signed [23:0] v0;
        logic signed [23:0] v1;
        logic [7:0]         elem_base;
        logic [5:0][7:0]    data;
    } job_t;

    function automatic logic is_heartbeat(input logic [10:0] id);
        return id inside {11'h244, 11'h245, 11'h286, 11'h344, 11'h345, 11'h347,
                          11'h34a, 11'h35e, 11'h360, 11'h36c, 11'h438, 11'h43a,
                          11'h43b, 11'h43c, 11'h43d, 11'h444, 11'h445, 11'h446,
                          11'h447, 11'h47b, 11'h524};
    endfunction

    function automatic logic signed [23:0] to_degc(input logic [7:0] b);
        return $signed({16'd0, b}) - DEGC_OFFSET;
    endfunction

endpackage

/* hdl/bctd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_front
// Accepts frames and ticks, keeps the watchdog and cell minimum, and
// classifies each item into a job for the back end.
// ----------------------------------------------------------------------------
module bctd_front
    import bctd_pkg::*;
#(
    parameter int PACK_SENSORS = PACK_SENSORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        q_full,
    output logic        push,
    output job_t        push_job
);

    logic        running_reg, running_next;
    logic [15:0] wdog_left_reg, wdog_left_next;
    logic [15:0] min_cell_reg, min_cell_next;
    logic        min_seen_reg, min_seen_next;
    logic [7:0]  cell_count_reg;
    logic [15:0] wdog_ticks_reg;

    logic        accept;
    logic        frame_ok;
    logic [15:0] uv;
    logic [15:0] pid;
    logic [10:0] pack_base;
    logic [10:0] pack_rem;
    logic [9:0]  cell_base;
    logic [9:0]  cell_rem;
    job_t        job;

    assign in_ready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign frame_ok  = !in_item.action && (in_item.frame_len == FRAME_LEN_FULL);
    assign uv        = {in_item.byte5, in_item.byte4};
    assign pid       = {in_item.byte2, in_item.byte3};
    assign pack_base = 11'(in_item.byte0) * 11'(PACK_PER_FRAME);
    assign pack_rem  = 11'(PACK_SENSORS) - pack_base;
    assign cell_base = 10'(in_item.byte0) * 10'(CELL_PER_FRAME);
    assign cell_rem  = 10'(cell_count_reg) - cell_base;

    always_comb
    begin
        running_next   = running_reg;
        wdog_left_next = wdog_left_reg;
        min_cell_next  = min_cell_reg;
        min_seen_next  = min_seen_reg;
        job            = '0;
        job.vmode      = VMODE_SCALAR;
        job.data       = {in_item.byte6, in_item.byte5, in_item.byte4,
                          in_item.byte3, in_item.byte2, in_item.byte1};

        if (in_item.action)
        begin
            if (wdog_left_reg != 16'd0)
            begin
                wdog_left_next = wdog_left_reg - 16'd1;
                if (wdog_left_reg == 16'd1 && running_reg)
                begin
                    running_next = 1'b0;
                    job.run_emit = 1'b1;
                    job.run_val  = 1'b0;
                end
            end
        end
        else if (frame_ok)
        begin
            if (is_heartbeat(in_item.can_id))
            begin
                if (!running_reg)
                begin
                    job.run_emit = 1'b1;
                    job.run_val  = 1'b1;
                end
                running_next   = 1'b1;
                wdog_left_next = (wdog_ticks_reg == 16'd0) ? 16'd1 : wdog_ticks_reg;
            end

            case (in_item.can_id)
                ID_AMBIENT:
                begin
                    if (in_item.byte0 == SUBTYPE_AMBIENT)
                    begin
                        job.nval = 3'd1;
                        job.q0   = Q_AMBIENT;
                        job.v0   = to_degc(in_item.byte4);
                    end
                end
                ID_PACK_TEMP:
                begin
                    job.vmode     = VMODE_PACK;
                    job.elem_base = pack_base[7:0];
                    if (pack_base >= 11'(PACK_SENSORS))
                        job.nval = 3'd0;
                    else if (pack_rem > 11'(PACK_PER_FRAME))
                        job.nval = 3'(PACK_PER_FRAME);
                    else
                        job.nval = pack_rem[2:0];
                end
                ID_CELL_MV:
                begin
                    job.vmode     = VMODE_CELL;
                    job.elem_base = cell_base[7:0];
                    if (cell_base >= 10'(cell_count_reg))
                        job.nval = 3'd0;
                    else if (cell_rem > 10'(CELL_PER_FRAME))
                        job.nval = 3'(CELL_PER_FRAME);
                    else
                        job.nval = cell_rem[2:0];
                end
                ID_PACK_VOLT:
                begin
                    job.nval = 3'd1;
                    job.q0   = Q_PACK_VOLT;
                    job.v0   = $signed({8'd0, in_item.byte1, in_item.byte0});
                end
                ID_SOC:
                begin
                    job.nval = 3'd1;
                    job.q0   = Q_SOC;
                    job.v0   = $signed({8'd0, uv});
                end
                ID_PID_REPLY:
                begin
                    job.ack  = (in_item.byte0 == FIRST_FRAME);
                    job.nval = 3'd1;
                    job.v0   = $signed({8'd0, uv});
                    case (pid)
                        PID_SOC:
                        begin
                            job.q0 = Q_PID_SOC;
                            job.v0 = $signed({16'd0, in_item.byte4});
                        end
                        PID_VOLTAGE:   job.q0 = Q_PID_VOLT;
                        PID_CURRENT:
                        begin
                            job.q0 = Q_PID_CURRENT;
                            job.v0 = $signed({8'd0, uv}) - CURRENT_OFFSET;
                        end
                        PID_TEMP_MIN:
                        begin
                            job.q0 = Q_TEMP_MIN;
                            job.v0 = to_degc(in_item.byte4);
                        end
                        PID_TEMP_MAX:
                        begin
                            job.q0 = Q_TEMP_MAX;
                            job.v0 = to_degc(in_item.byte4);
                        end
                        PID_TEMP_AVG:
                        begin
                            job.q0 = Q_TEMP_AVG;
                            job.v0 = to_degc(in_item.byte4);
                        end
                        PID_CELL_MV_MIN:
                        begin
                            job.q0        = Q_CELL_MIN;
                            min_cell_next = uv;
                            min_seen_next = 1'b1;
                        end
                        PID_CELL_MV_MAX:
                        begin
                            job.q0 = Q_CELL_MAX;
                            job.v1 = $signed({8'd0, uv - min_cell_reg});
                            // spread only against a known, not larger minimum
                            if (min_seen_reg && uv >= min_cell_reg)
                                job.nval = 3'd2;
                        end
                        PID_CHG_POWER:
                        begin
                            job.q0 = Q_CHG_POWER;
                            job.v0 = $signed(24'(uv) * POWER_SCALE);
                        end
                        PID_DIS_POWER:
                        begin
                            job.q0 = Q_DIS_POWER;
                            job.v0 = $signed(24'(uv) * POWER_SCALE);
                        end
                        PID_CHG_COUNT: job.q0 = Q_CHG_COUNT;
                        PID_CHG_AH:    job.q0 = Q_CHG_AH;
                        PID_DIS_AH:    job.q0 = Q_DIS_AH;
                        PID_CHG_KWH:   job.q0 = Q_CHG_KWH;
                        PID_DIS_KWH:   job.q0 = Q_DIS_KWH;
                        default:       job.nval = 3'd0;
                    endcase
                end
                default:
                begin
                    job.nval = 3'd0;
                end
            endcase
        end
    end

    // Drop items that produce no result
    assign push     = accept && (job.run_emit || job.ack || (job.nval != 3'd0));
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg    <= 1'b0;
            wdog_left_reg  <= 16'd0;
            min_cell_reg   <= 16'd0;
            min_seen_reg   <= 1'b0;
            cell_count_reg <= CELL_COUNT_RST;
            wdog_ticks_reg <= WDOG_TICKS_RST;
        end
        else
        begin
            if (accept)
            begin
                running_reg   <= running_next;
                wdog_left_reg <= wdog_left_next;
                min_cell_reg  <= min_cell_next;
                min_seen_reg  <= min_seen_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CELL_COUNT: cell_count_reg <= cfg_data[7:0];
                    CFG_WDOG_TICKS: wdog_ticks_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

endmodule

/* hdl/bctd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_queue
// Short job queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module bctd_queue
    import bctd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + QPTR_W'(1);
            if (push && !do_pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (do_pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

/* hdl/bctd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_back
// Loads the head job's results into the output register, one per unstalled cycle.
// ----------------------------------------------------------------------------
module bctd_back
    import bctd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  job_t head_job,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_item
);

    logic [2:0] idx_reg;
    logic [2:0] vidx;
    logic [2:0] lo_sel;
    logic [2:0] hi_sel;
    logic [3:0] total;
    logic       is_last;
    logic       adv;
    logic       out_valid_reg;
    out_t       out_item_reg;
    out_t       item;

    assign total   = 4'(head_job.run_emit) + 4'(head_job.ack) + 4'(head_job.nval);
    assign is_last = ({1'b0, idx_reg} == total - 4'd1);
    assign vidx    = idx_reg - 3'(head_job.run_emit) - 3'(head_job.ack);
    assign lo_sel  = {vidx[1:0], 1'b0};
    assign hi_sel  = {vidx[1:0], 1'b1};

    always_comb
    begin
        item      = '0;
        item.last = is_last;
        if (head_job.run_emit && idx_reg == 3'd0)
        begin
            item.kind  = KIND_RUN;
            item.value = $signed({23'd0, head_job.run_val});
        end
        else if (head_job.ack && idx_reg == 3'(head_job.run_emit))
        begin
            item.kind = KIND_ACK;
        end
        else
        begin
            item.kind = KIND_VALUE;
            case (head_job.vmode)
                VMODE_PACK:
                begin
                    item.quantity = Q_PACK_TEMP;
                    item.element  = head_job.elem_base + 8'(vidx);
                    item.value    = to_degc(head_job.data[vidx]);
                end
                VMODE_CELL:
                begin
                    item.quantity = Q_CELL_MV;
                    item.element  = head_job.elem_base + 8'(vidx);
                    item.value    = $signed({8'd0, head_job.data[hi_sel],
                                             head_job.data[lo_sel]});
                end
                default:
                begin
                    if (vidx == 3'd0)
                    begin
                        item.quantity = head_job.q0;
                        item.value    = head_job.v0;
                    end
                    else
                    begin
                        item.quantity = Q_CELL_SPREAD;
                        item.value    = head_job.v1;
                    end
                end
            endcase
        end
    end

    assign adv       = head_valid && (!out_valid_reg || out_ready);
    assign pop       = adv && is_last;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_last ? 3'd0 : idx_reg + 3'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/battery_can_telemetry_decoder_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_can_telemetry_decoder_core
// Decodes received CAN frames and timer ticks into telemetry results.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+--------------------------------
//  in      | in_valid / in_ready   | in_item  (frame or tick)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//  out     | out_valid / out_ready | out_item (one result)
//
//  Each accepted item yields 1 to 7 results; items with none are dropped.
//  Results leave one per cycle while out_ready allows, and an item holds the
//  back end until its last result is loaded. An item passes the job queue and
//  the output register before its first result shows in out_item. A four-entry
//  job queue lets the front keep taking items while output stalls, until full.
//  Reset clears the watchdog, running flag and cell minimum and loads the
//  configuration defaults; no clearing pass is needed. cfg_ready is always high.
// ----------------------------------------------------------------------------
module battery_can_telemetry_decoder_core
    import bctd_pkg::*;
#(
    parameter int PACK_SENSORS = PACK_SENSORS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_item
);

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic head_valid;
    job_t head_job;

    bctd_front #(
        .PACK_SENSORS (PACK_SENSORS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    bctd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bctd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

endmodule

/* hdl/bctd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bctd_checker
// Port-level checks on the telemetry decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bctd_checker
    import bctd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input in_t         in_item,
    input logic        out_valid,
    input logic        out_ready,
    input out_t        out_item
);

    // Hold a stalled input transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("stalled input changed");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("stalled result changed");

    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_ACK |->
            out_item.quantity == Q_AMBIENT && out_item.element == 8'd0 &&
            out_item.value == 24'sd0)
        else $error("ack request carries payload");

    a_run_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_RUN |->
            out_item.element == 8'd0 &&
            (out_item.value == 24'sd0 || out_item.value == 24'sd1))
        else $error("running change value out of range");

    a_element_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.quantity != Q_PACK_TEMP &&
            out_item.quantity != Q_CELL_MV |-> out_item.element == 8'd0)
        else $error("element set on scalar quantity");

endmodule

bind battery_can_telemetry_decoder_core bctd_checker u_bctd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_can_telemetry_decoder_core. A directed
// table of frames and ticks runs first, then random traffic under five
// register settings. Every result is compared field by field against a local
// decoder model or a typed expectation, and both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    import bctd_pkg::*;

    typedef struct {
        in_t  item;
        int   nexp;      // -1: use the model, 0 or 1: typed below
        out_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_t         in_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_item;

    // Model state and registers
    logic [7:0]  m_cells;
    logic [15:0] m_wdog_ticks;
    logic        m_running;
    logic [15:0] m_wdog_left;
    logic [15:0] m_min_mv;
    logic        m_min_seen;

    out_t telemetry_due[$];
    int   errors;
    int   n_items;
    int   n_ticks;
    int   n_results;
    bit   steady;

    logic [10:0] beat_ids [0:20] = '{
        11'h244, 11'h245, 11'h286, 11'h344, 11'h345, 11'h347, 11'h34a,
        11'h35e, 11'h360, 11'h36c, 11'h438, 11'h43a, 11'h43b, 11'h43c,
        11'h43d, 11'h444, 11'h445, 11'h446, 11'h447, 11'h47b, 11'h524};

    logic [15:0] pid_pick [0:16] = '{
        PID_SOC, PID_VOLTAGE, PID_CURRENT, PID_CHG_POWER, PID_CHG_COUNT,
        PID_DIS_POWER, PID_CHG_AH, PID_DIS_AH, PID_CHG_KWH, PID_DIS_KWH,
        PID_CELL_MV_MIN, PID_CELL_MV_MAX, PID_TEMP_MIN, PID_TEMP_MAX,
        PID_TEMP_AVG, PID_CELL_MV_MIN, PID_CELL_MV_MAX};

    int ph_cells [0:4] = '{0, 255, 1, 7, 126};
    int ph_ticks [0:4] = '{0, 65535, 1, 3, 5};
    int ph_items [0:4] = '{60, 60, 60, 150, 140};

    battery_can_telemetry_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic out_t mk(logic [1:0] k, logic [4:0] q, int e, int v);
        out_t r;
        r.kind     = k;
        r.quantity = q;
        r.element  = e[7:0];
        r.value    = v[23:0];
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic out_t one(logic [4:0] q, int v);
        out_t r;
        r      = mk(KIND_VALUE, q, 0, v);
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int degc(logic [7:0] b);
        return int'(b) - 40;
    endfunction

    function automatic in_t frame(logic [10:0] id, logic [3:0] len, logic [63:0] data);
        in_t it;
        it.action    = 1'b0;
        it.can_id    = id;
        it.frame_len = len;
        {it.byte0, it.byte1, it.byte2, it.byte3,
         it.byte4, it.byte5, it.byte6, it.byte7} = data;
        return it;
    endfunction

    function automatic in_t pid_frame(logic [7:0] b0, logic [15:0] pid, logic [15:0] uv);
        return frame(ID_PID_REPLY, FRAME_LEN_FULL,
                     {b0, 8'h5a, pid, uv[7:0], uv[15:8], 16'hc3e1});
    endfunction

    // Work out the results of one item and advance the model state.
    function automatic void predict_telemetry(in_t it, bit keep);
        out_t        r[$];
        logic [7:0]  d[8];
        logic [15:0] uv;
        logic [15:0] pid;
        int          base;
        bit          beat;
        d    = '{it.byte0, it.byte1, it.byte2, it.byte3,
                 it.byte4, it.byte5, it.byte6, it.byte7};
        uv   = {d[5], d[4]};
        pid  = {d[2], d[3]};
        beat = 1'b0;
        if (it.action)
        begin
            if (m_wdog_left != 16'd0)
            begin
                m_wdog_left--;
                if (m_wdog_left == 16'd0 && m_running)
                begin
                    m_running = 1'b0;
                    r.push_back(mk(KIND_RUN, 5'd0, 0, 0));
                end
            end
        end
        else if (it.frame_len == FRAME_LEN_FULL)
        begin
            foreach (beat_ids[i])
                if (beat_ids[i] == it.can_id)
                    beat = 1'b1;
            if (beat)
            begin
                if (!m_running)
                    r.push_back(mk(KIND_RUN, 5'd0, 0, 1));
                m_running   = 1'b1;
                m_wdog_left = (m_wdog_ticks != 16'd0) ? m_wdog_ticks : 16'd1;
            end
            case (it.can_id)
                ID_AMBIENT:
                    if (d[0] == SUBTYPE_AMBIENT)
                        r.push_back(mk(KIND_VALUE, Q_AMBIENT, 0, degc(d[4])));
                ID_PACK_TEMP:
                begin
                    base = int'(d[0]) * 6;
                    for (int i = 0; i < 6; i++)
                    begin
                        if (base + i >= PACK_SENSORS_DEF)
                            break;
                        r.push_back(mk(KIND_VALUE, Q_PACK_TEMP, base + i, degc(d[1 + i])));
                    end
                end
                ID_CELL_MV:
                begin
                    base = int'(d[0]) * 3;
                    for (int i = 0; i < 3; i++)
                    begin
                        if (base + i >= int'(m_cells))
                            break;
                        r.push_back(mk(KIND_VALUE, Q_CELL_MV, base + i,
                                       int'({d[2 + 2 * i], d[1 + 2 * i]})));
                    end
                end
                ID_PACK_VOLT: r.push_back(mk(KIND_VALUE, Q_PACK_VOLT, 0, int'({d[1], d[0]})));
                ID_SOC:       r.push_back(mk(KIND_VALUE, Q_SOC, 0, int'(uv)));
                ID_PID_REPLY:
                begin
                    if (d[0] == FIRST_FRAME)
                        r.push_back(mk(KIND_ACK, 5'd0, 0, 0));
                    case (pid)
                        PID_SOC:     r.push_back(mk(KIND_VALUE, Q_PID_SOC, 0, int'(d[4])));
                        PID_VOLTAGE: r.push_back(mk(KIND_VALUE, Q_PID_VOLT, 0, int'(uv)));
                        PID_CURRENT: r.push_back(mk(KIND_VALUE, Q_PID_CURRENT, 0,
                                                    int'(uv) - 5000));
                        PID_TEMP_MIN: r.push_back(mk(KIND_VALUE, Q_TEMP_MIN, 0, degc(d[4])));
                        PID_TEMP_MAX: r.push_back(mk(KIND_VALUE, Q_TEMP_MAX, 0, degc(d[4])));
                        PID_TEMP_AVG: r.push_back(mk(KIND_VALUE, Q_TEMP_AVG, 0, degc(d[4])));
                        PID_CELL_MV_MIN:
                        begin
                            m_min_mv   = uv;
                            m_min_seen = 1'b1;
                            r.push_back(mk(KIND_VALUE, Q_CELL_MIN, 0, int'(uv)));
                        end
                        PID_CELL_MV_MAX:
                        begin
                            r.push_back(mk(KIND_VALUE, Q_CELL_MAX, 0, int'(uv)));
                            if (m_min_seen && uv >= m_min_mv)
                                r.push_back(mk(KIND_VALUE, Q_CELL_SPREAD, 0,
                                               int'(uv) - int'(m_min_mv)));
                        end
                        PID_CHG_POWER: r.push_back(mk(KIND_VALUE, Q_CHG_POWER, 0,
                                                      int'(uv) * 100));
                        PID_DIS_POWER: r.push_back(mk(KIND_VALUE, Q_DIS_POWER, 0,
                                                      int'(uv) * 100));
                        PID_CHG_COUNT: r.push_back(mk(KIND_VALUE, Q_CHG_COUNT, 0, int'(uv)));
                        PID_CHG_AH:    r.push_back(mk(KIND_VALUE, Q_CHG_AH, 0, int'(uv)));
                        PID_DIS_AH:    r.push_back(mk(KIND_VALUE, Q_DIS_AH, 0, int'(uv)));
                        PID_CHG_KWH:   r.push_back(mk(KIND_VALUE, Q_CHG_KWH, 0, int'(uv)));
                        PID_DIS_KWH:   r.push_back(mk(KIND_VALUE, Q_DIS_KWH, 0, int'(uv)));
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        if (r.size() > 0)
            r[r.size() - 1].last = 1'b1;
        if (keep)
            foreach (r[i])
                telemetry_due.push_back(r[i]);
    endfunction

    // Mostly well-formed frames with random content, some ticks and noise.
    function automatic in_t rand_item();
        in_t         it;
        logic [95:0] raw;
        int          r;
        raw          = {$urandom, $urandom, $urandom};
        it           = raw[79:0];
        it.action    = 1'b0;
        if ($urandom_range(0, 99) < 20)
        begin
            it.action = 1'b1;
            return it;
        end
        it.frame_len = ($urandom_range(0, 99) < 88) ? FRAME_LEN_FULL
                                                     : 4'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            it.can_id = ID_AMBIENT;
            if ($urandom_range(0, 99) < 70)
                it.byte0 = SUBTYPE_AMBIENT;
        end
        else if (r < 27)
        begin
            it.can_id = ID_PACK_TEMP;
            if ($urandom_range(0, 99) < 70)
                it.byte0 = 8'($urandom_range(0, 2));
        end
        else if (r < 42)
        begin
            it.can_id = ID_CELL_MV;
            case ($urandom_range(0, 3))
                0, 1: it.byte0 = 8'($urandom_range(0, 3));
                2:    it.byte0 = 8'($urandom_range(83, 86));
                default: ;
            endcase
        end
        else if (r < 50)
        begin
            it.can_id = ID_PACK_VOLT;
        end
        else if (r < 58)
        begin
            it.can_id = ID_SOC;
        end
        else if (r < 80)
        begin
            it.can_id = ID_PID_REPLY;
            if ($urandom_range(0, 1) == 0)
                it.byte0 = FIRST_FRAME;
            if ($urandom_range(0, 99) < 85)
                {it.byte2, it.byte3} = pid_pick[$urandom_range(0, 16)];
        end
        else if (r < 90)
        begin
            it.can_id = beat_ids[$urandom_range(0, 20)];
        end
        return it;
    endfunction

    function automatic void check_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function automatic void check_result(out_t got);
        out_t want;
        n_results++;
        if (telemetry_due.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none, actual kind %0d quantity %0d",
                     $time, got.kind, got.quantity);
            return;
        end
        want = telemetry_due.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("quantity", want.quantity, got.quantity);
        check_field("element", want.element, got.element);
        check_field("value", want.value, got.value);
        check_field("last", want.last, got.last);
    endfunction

    // Output side: ready is stable by the falling edge, so a transfer seen
    // there completes at the next rising edge.
    always @(negedge clk)
        if (rst_n && out_valid && out_ready)
            check_result(out_item);

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send(input in_t it, input int nexp, input out_t res);
        bit rdy;
        // Idle at random so about a third of the cycles stay empty
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 33)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do
        begin
            @(negedge clk);
            rdy = in_ready;
            @(posedge clk);
        end while (!rdy);
        predict_telemetry(it, nexp < 0);
        if (nexp == 1)
            telemetry_due.push_back(res);
        n_items++;
        if (it.action)
            n_ticks++;
        steady = (n_items >= 230 && n_items < 310);
    endtask

    task automatic cfg_xfer();
        bit rdy;
        do
        begin
            @(negedge clk);
            rdy = cfg_ready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic set_cfg(input int cells, input int ticks);
        logic [7:0] junk;
        junk      = 8'($urandom);
        cfg_index <= CFG_CELL_COUNT;
        cfg_data  <= {junk, cells[7:0]};
        cfg_valid <= 1'b1;
        cfg_xfer();
        m_cells   = cells[7:0];
        cfg_index <= CFG_WDOG_TICKS;
        cfg_data  <= ticks[15:0];
        cfg_xfer();
        m_wdog_ticks = ticks[15:0];
        cfg_valid <= 1'b0;
    endtask

    // Hold input idle until all results are back, then let the pipe drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (telemetry_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        stim_row_t   dir_rows[$];
        stim_row_t   row;
        in_t         it;
        logic [15:0] misc_pids [0:7] = '{PID_SOC, PID_VOLTAGE, PID_CHG_COUNT, PID_CHG_AH,
                                        PID_DIS_AH, PID_CHG_KWH, PID_DIS_KWH, PID_TEMP_AVG};
        int          k;
        int          lim;
        int          burst;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_CELL_COUNT;
        cfg_data  = '0;
        errors    = 0;
        n_items   = 0;
        n_ticks   = 0;
        n_results = 0;
        steady    = 1'b0;

        m_cells      = CELL_COUNT_RST;
        m_wdog_ticks = WDOG_TICKS_RST;
        m_running    = 1'b0;
        m_wdog_left  = '0;
        m_min_mv     = '0;
        m_min_seen   = 1'b0;

        // Directed table, reset register values
        it        = '0;
        it.action = 1'b1;
        dir_rows.push_back('{it, 0, '0});
        dir_rows.push_back('{frame(ID_AMBIENT, 4'd7, 64'h0100_0000_8000_0000), 0, '0});
        dir_rows.push_back('{pid_frame(8'h00, PID_CURRENT, 16'h0000), 1,
                             one(Q_PID_CURRENT, -5000)});
        dir_rows.push_back('{pid_frame(8'h00, PID_CURRENT, 16'hffff), 1,
                             one(Q_PID_CURRENT, 60535)});
        dir_rows.push_back('{pid_frame(8'h00, PID_DIS_POWER, 16'hffff), 1,
                             one(Q_DIS_POWER, 6553500)});
        dir_rows.push_back('{pid_frame(8'h00, PID_CHG_POWER, 16'h0000), 1,
                             one(Q_CHG_POWER, 0)});
        dir_rows.push_back('{pid_frame(8'h00, PID_TEMP_MIN, 16'h0000), 1,
                             one(Q_TEMP_MIN, -40)});
        dir_rows.push_back('{pid_frame(8'h00, PID_TEMP_MAX, 16'h00ff), 1,
                             one(Q_TEMP_MAX, 215)});
        // No minimum yet: max alone, no spread
        dir_rows.push_back('{pid_frame(8'h00, PID_CELL_MV_MAX, 16'd1000), 1,
                             one(Q_CELL_MAX, 1000)});
        dir_rows.push_back('{pid_frame(8'h00, 16'hffff, 16'd1234), 0, '0});
        row.res      = mk(KIND_ACK, 5'd0, 0, 0);
        row.res.last = 1'b1;
        dir_rows.push_back('{pid_frame(FIRST_FRAME, 16'h0000, 16'd0), 1, row.res});
        foreach (misc_pids[i])
            dir_rows.push_back('{pid_frame(8'($urandom), misc_pids[i], 16'($urandom)), -1, '0});
        // First heartbeat raises running
        dir_rows.push_back('{frame(ID_AMBIENT, FRAME_LEN_FULL, 64'h0100_0000_8000_0000),
                             -1, '0});
        dir_rows.push_back('{frame(ID_AMBIENT, FRAME_LEN_FULL, 64'h0133_4455_ff00_0000), 1,
                             one(Q_AMBIENT, 215)});
        dir_rows.push_back('{frame(ID_PACK_TEMP, FRAME_LEN_FULL, 64'h0000_28ff_5060_7080),
                             -1, '0});
        dir_rows.push_back('{frame(ID_PACK_TEMP, FRAME_LEN_FULL, 64'h0111_2233_4455_6677),
                             -1, '0});
        dir_rows.push_back('{frame(ID_CELL_MV, FRAME_LEN_FULL, 64'h00ff_ff00_0034_12aa),
                             -1, '0});
        dir_rows.push_back('{frame(ID_CELL_MV, FRAME_LEN_FULL, 64'h2901_0203_0405_06bb),
                             -1, '0});
        dir_rows.push_back('{frame(ID_CELL_MV, FRAME_LEN_FULL, 64'h2a01_0203_0405_06cc),
                             0, '0});
        dir_rows.push_back('{frame(ID_PACK_VOLT, FRAME_LEN_FULL, 64'hffff_0000_0000_0000), 1,
                             one(Q_PACK_VOLT, 65535)});
        dir_rows.push_back('{frame(ID_SOC, FRAME_LEN_FULL, 64'h0000_0000_5a00_0000), -1, '0});
        dir_rows.push_back('{pid_frame(FIRST_FRAME, PID_CELL_MV_MIN, 16'd500), -1, '0});
        dir_rows.push_back('{pid_frame(8'h00, PID_CELL_MV_MAX, 16'd800), -1, '0});
        // Max below the stored minimum: no spread
        dir_rows.push_back('{pid_frame(8'h00, PID_CELL_MV_MAX, 16'd100), 1,
                             one(Q_CELL_MAX, 100)});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send(dir_rows[i].item, dir_rows[i].nexp, dir_rows[i].res);
        settle();

        for (int p = 0; p < 5; p++)
        begin
            set_cfg(ph_cells[p], ph_ticks[p]);
            k = 0;
            while (k < ph_items[p])
            begin
                if ($urandom_range(0, 99) < 6)
                begin
                    // Run of up to eight ticks, long enough to let a short watchdog expire
                    lim = int'(m_wdog_ticks) + 1;
                    if (lim > 8)
                        lim = 8;
                    burst = $urandom_range(1, lim);
                    it        = rand_item();
                    it.action = 1'b1;
                    repeat (burst)
                        send(it, -1, '0);
                    k += burst;
                end
                else
                begin
                    send(rand_item(), -1, '0);
                    k++;
                end
            end
            settle();
        end

        $display("Drove %0d items (%0d ticks) over the reset registers and five settings,",
                 n_items, n_ticks);
        $display("and compared %0d results against the decoder model.", n_results);
        if (errors == 0)
            $display("battery_can_telemetry_decoder_core verification clean");
        else
            $display("battery_can_telemetry_decoder_core verification failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding", telemetry_due.size());
        $display("battery_can_telemetry_decoder_core verification failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/bctd_pkg.sv
hdl/bctd_front.sv
hdl/bctd_queue.sv
hdl/bctd_back.sv
hdl/battery_can_telemetry_decoder_core.sv
hdl/bctd_checker.sv
verif/tb.sv
